[rtl/sgeos_pkg.sv]
// ----------------------------------------------------------------------------
// sgeos_pkg
// shared constants, register codes and the restoring divide step for the
// stiffened-gas cell equation of state unit
// ----------------------------------------------------------------------------
package sgeos_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ALPHA_W     = 17;
    localparam int MASS_W      = 31;
    localparam int GAMMA_W     = 24;
    localparam int STIFF_W     = 31;
    localparam int DATA_W      = 32;
    localparam int TERM_W      = 41;

    // pipelined divide and root step counts
    localparam int KIN_STEPS   = 63;
    localparam int QDIV_STEPS  = 56;
    localparam int SQRT_STEPS  = 31;
    localparam int VEL_STEPS   = 49;

    localparam int PHASE_LAT   = 1 + (KIN_STEPS + 1) + 5 + (QDIV_STEPS + 1) + 1
                                 + (SQRT_STEPS + 1);
    localparam int VEL_LAT     = 1 + (VEL_STEPS + 1) + 2;
    localparam int VEL_PAD     = PHASE_LAT - VEL_LAT;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'd65536;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET   = 24'd91750;
    localparam logic [STIFF_W-1:0] STIFF_RESET   = 31'd0;
    localparam logic [30:0]        UMAX          = 31'h7fff_ffff;

    typedef enum logic [1:0] {
        CFG_GAMMA_FIRST,
        CFG_STIFF_FIRST,
        CFG_GAMMA_SECOND,
        CFG_STIFF_SECOND
    } cfg_index_t;

    // one restoring step: returns {remainder, quotient bit}
    function automatic logic [32:0] div_step(input logic [31:0] rem,
                                             input logic        nbit,
                                             input logic [31:0] dvs);
        logic [32:0] sh;
        logic [32:0] dif;
        begin
            sh  = {rem, nbit};
            dif = sh - {1'b0, dvs};
            if (dif[32])
                div_step = {sh[31:0], 1'b0};
            else
                div_step = {dif[31:0], 1'b1};
        end
    endfunction

endpackage

[rtl/stiffened_gas_cell_eos_unit.sv]
// ----------------------------------------------------------------------------
// stiffened_gas_cell_eos_unit
// stiffened-gas equation of state for one two-phase cell: phasic pressures,
// interface pressure and velocity, sound speeds, with a divide fault flag
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   in_valid / in_ready    volume fraction, mass, momentum, energy x2
//  result    out_valid / out_ready  pressures, interface terms, sound speeds
//  config    cfg_write              cfg_index, cfg_data
//
//  one request per cycle while in_ready is high; 160 pipeline stages set by
//  the kinetic, quotient and root step chains, the first loaded at the
//  accepting edge, then the output register
//  reset clears all valid bits and loads the register reset values
//  a held result stalls the pipeline only when its last stage is occupied
// ----------------------------------------------------------------------------
module stiffened_gas_cell_eos_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [16:0]         volume_fraction,
    input  logic [30:0]         mass_first,
    input  logic signed [31:0]  momentum_first,
    input  logic signed [31:0]  energy_first,
    input  logic [30:0]         mass_second,
    input  logic signed [31:0]  momentum_second,
    input  logic signed [31:0]  energy_second,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pressure_first,
    output logic signed [31:0]  pressure_second,
    output logic [30:0]         interface_pressure,
    output logic signed [31:0]  interface_velocity,
    output logic [30:0]         sound_speed_first,
    output logic [30:0]         sound_speed_second,
    output logic                divide_fault
);

    localparam int LAT = sgeos_pkg::PHASE_LAT;
    localparam int VS  = sgeos_pkg::VEL_STEPS;
    localparam int VP  = sgeos_pkg::VEL_PAD;

    // configuration registers
    logic [23:0] gamma_first_reg, gamma_second_reg;
    logic [30:0] stiff_first_reg, stiff_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_first_reg  <= sgeos_pkg::GAMMA_RESET;
            stiff_first_reg  <= sgeos_pkg::STIFF_RESET;
            gamma_second_reg <= sgeos_pkg::GAMMA_RESET;
            stiff_second_reg <= sgeos_pkg::STIFF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (sgeos_pkg::cfg_index_t'(cfg_index))
                sgeos_pkg::CFG_GAMMA_FIRST:  gamma_first_reg  <= cfg_data[23:0];
                sgeos_pkg::CFG_STIFF_FIRST:  stiff_first_reg  <= cfg_data;
                sgeos_pkg::CFG_GAMMA_SECOND: gamma_second_reg <= cfg_data[23:0];
                sgeos_pkg::CFG_STIFF_SECOND: stiff_second_reg <= cfg_data;
            endcase
        end
    end

    // pipeline control
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic           out_valid_reg;

    assign en       = !out_valid_reg || out_ready || !vld_reg[LAT-1];
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
            if (en && vld_reg[LAT-1])
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // volume fractions and fault
    logic [16:0] alpha_first, alpha_second;
    logic        fault_in;
    logic        flt_reg [LAT];

    assign alpha_first  = (volume_fraction > sgeos_pkg::ALPHA_ONE) ? sgeos_pkg::ALPHA_ONE
                                                                   : volume_fraction;
    assign alpha_second = sgeos_pkg::ALPHA_ONE - alpha_first;
    assign fault_in     = (alpha_first == 17'd0) || (alpha_second == 17'd0)
                          || (mass_first == 31'd0) || (mass_second == 31'd0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flt_reg[0] <= fault_in;
            for (int k = 1; k < LAT; k++)
                flt_reg[k] <= flt_reg[k-1];
        end
    end

    // phases
    logic signed [31:0] p1, p2;
    logic [40:0]        t1, t2;
    logic [30:0]        c1, c2;

    sgeos_phase u_phase_first (
        .clk         (clk),
        .en          (en),
        .alpha       (alpha_first),
        .mass        (mass_first),
        .momentum    (momentum_first),
        .energy      (energy_first),
        .gamma       (gamma_first_reg),
        .stiffening  (stiff_first_reg),
        .pressure    (p1),
        .term        (t1),
        .sound_speed (c1)
    );

    sgeos_phase u_phase_second (
        .clk         (clk),
        .en          (en),
        .alpha       (alpha_second),
        .mass        (mass_second),
        .momentum    (momentum_second),
        .energy      (energy_second),
        .gamma       (gamma_second_reg),
        .stiffening  (stiff_second_reg),
        .pressure    (p2),
        .term        (t2),
        .sound_speed (c2)
    );

    // interface velocity
    logic signed [32:0] qsum_reg;
    logic [31:0]        msum_reg;
    logic [32:0]        qsum_abs;
    logic [48:0]        vacc_reg [VS+1];
    logic [31:0]        vrem_reg [VS+1];
    logic [31:0]        vdiv_reg [VS+1];
    logic               vneg_reg [VS+1];
    logic [32:0]        vstep    [VS];
    logic signed [49:0] vq_pos;
    logic signed [49:0] vq_reg;
    logic signed [31:0] vclamp_reg;
    logic signed [31:0] vpad_reg [VP];

    assign qsum_abs = qsum_reg[32] ? 33'(-qsum_reg) : 33'(qsum_reg);
    assign vq_pos   = $signed({1'b0, vacc_reg[VS]});

    always_comb
    begin
        for (int k = 0; k < VS; k++)
            vstep[k] = sgeos_pkg::div_step(vrem_reg[k], vacc_reg[k][48], vdiv_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qsum_reg    <= 33'(momentum_first) + 33'(momentum_second);
            msum_reg    <= 32'(mass_first) + 32'(mass_second);
            vacc_reg[0] <= {qsum_abs, 16'd0};
            vrem_reg[0] <= '0;
            vdiv_reg[0] <= msum_reg;
            vneg_reg[0] <= qsum_reg[32];
            for (int k = 0; k < VS; k++)
            begin
                vacc_reg[k+1] <= {vacc_reg[k][47:0], vstep[k][0]};
                vrem_reg[k+1] <= vstep[k][32:1];
                vdiv_reg[k+1] <= vdiv_reg[k];
                vneg_reg[k+1] <= vneg_reg[k];
            end
            vq_reg <= vneg_reg[VS] ? -vq_pos : vq_pos;
            if (vq_reg < -50'sd2147483648)
                vclamp_reg <= 32'sh8000_0000;
            else if (vq_reg > 50'sd2147483647)
                vclamp_reg <= 32'sh7fff_ffff;
            else
                vclamp_reg <= vq_reg[31:0];
            vpad_reg[0] <= vclamp_reg;
            for (int k = 1; k < VP; k++)
                vpad_reg[k] <= vpad_reg[k-1];
        end
    end

    // output register
    logic signed [31:0] p1_reg, p2_reg, vi_reg;
    logic [30:0]        pi_reg, c1_reg, c2_reg;
    logic               flt_out_reg;
    logic [41:0]        tsum;
    logic [30:0]        pi_sat;

    assign tsum   = 42'(t1) + 42'(t2);
    assign pi_sat = (tsum > 42'(sgeos_pkg::UMAX)) ? sgeos_pkg::UMAX : tsum[30:0];

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[LAT-1])
        begin
            flt_out_reg <= flt_reg[LAT-1];
            p1_reg      <= flt_reg[LAT-1] ? '0 : p1;
            p2_reg      <= flt_reg[LAT-1] ? '0 : p2;
            pi_reg      <= flt_reg[LAT-1] ? '0 : pi_sat;
            vi_reg      <= flt_reg[LAT-1] ? '0 : vpad_reg[VP-1];
            c1_reg      <= flt_reg[LAT-1] ? '0 : c1;
            c2_reg      <= flt_reg[LAT-1] ? '0 : c2;
        end
    end

    assign out_valid          = out_valid_reg;
    assign pressure_first     = p1_reg;
    assign pressure_second    = p2_reg;
    assign interface_pressure = pi_reg;
    assign interface_velocity = vi_reg;
    assign sound_speed_first  = c1_reg;
    assign sound_speed_second = c2_reg;
    assign divide_fault       = flt_out_reg;

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("request stalled without a held result");

    a_fault_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_fault) |-> (pressure_first == 32'sd0 && pressure_second == 32'sd0
            && interface_pressure == 31'd0 && interface_velocity == 32'sd0
            && sound_speed_first == 31'd0 && sound_speed_second == 31'd0))
        else $error("fault result carries non-zero fields");

    a_iface_floor : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !divide_fault) |-> (interface_pressure >= 31'd2))
        else $error("interface pressure below two clamped terms");

    a_sound_floor : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !divide_fault) |->
            (sound_speed_first >= 31'd256 && sound_speed_second >= 31'd256))
        else $error("sound speed below clamped floor");

endmodule

[rtl/sgeos_phase.sv]
// ----------------------------------------------------------------------------
// sgeos_phase
// one phase of the stiffened-gas law: kinetic energy divide, internal energy,
// pressure, interface term and sound speed, fully pipelined
// ----------------------------------------------------------------------------
module sgeos_phase (
    input  logic                clk,
    input  logic                en,
    input  logic [16:0]         alpha,
    input  logic [30:0]         mass,
    input  logic signed [31:0]  momentum,
    input  logic signed [31:0]  energy,
    input  logic [23:0]         gamma,
    input  logic [30:0]         stiffening,
    output logic signed [31:0]  pressure,
    output logic [40:0]         term,
    output logic [30:0]         sound_speed
);

    localparam int KS = sgeos_pkg::KIN_STEPS;
    localparam int QS = sgeos_pkg::QDIV_STEPS;
    localparam int SS = sgeos_pkg::SQRT_STEPS;

    localparam logic signed [63:0] LO64 = -64'sd2147483648;
    localparam logic signed [41:0] LO42 = -42'sd2147483648;
    localparam logic signed [41:0] HI42 = 42'sd2147483647;
    localparam logic signed [57:0] LO58 = -58'sd2147483648;
    localparam logic signed [57:0] HI58 = 58'sd2147483647;

    logic signed [24:0] g1;
    logic signed [24:0] gs;
    assign gs = $signed({1'b0, gamma});
    assign g1 = gs - 25'sd65536;

    // stage 1
    logic [31:0]        qa_reg;
    logic signed [31:0] e1_reg;
    logic [16:0]        a1_reg;
    logic [30:0]        m1_reg;
    logic [54:0]        gpf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qa_reg  <= momentum[31] ? (~momentum + 32'd1) : momentum;
            e1_reg  <= energy;
            a1_reg  <= alpha;
            m1_reg  <= mass;
            gpf_reg <= 55'(gamma) * 55'(stiffening);
        end
    end

    logic [63:0] sq_full;
    logic [55:0] agp_full;
    assign sq_full  = 64'(qa_reg) * 64'(qa_reg);
    assign agp_full = 56'(a1_reg) * 56'(gpf_reg[54:16]);

    // kinetic energy divide, q squared over twice the mass
    logic [62:0]        kacc_reg [KS+1];
    logic [31:0]        krem_reg [KS+1];
    logic [30:0]        km_reg   [KS+1];
    logic signed [31:0] ke_reg   [KS+1];
    logic [16:0]        ka_reg   [KS+1];
    logic [38:0]        kgp_reg  [KS+1];
    logic [39:0]        kagp_reg [KS+1];
    logic [32:0]        kstep    [KS];

    always_comb
    begin
        for (int k = 0; k < KS; k++)
            kstep[k] = sgeos_pkg::div_step(krem_reg[k], kacc_reg[k][62],
                                           {km_reg[k], 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kacc_reg[0] <= sq_full[62:0];
            krem_reg[0] <= '0;
            km_reg[0]   <= m1_reg;
            ke_reg[0]   <= e1_reg;
            ka_reg[0]   <= a1_reg;
            kgp_reg[0]  <= gpf_reg[54:16];
            kagp_reg[0] <= agp_full[55:16];
            for (int k = 0; k < KS; k++)
            begin
                kacc_reg[k+1] <= {kacc_reg[k][61:0], kstep[k][0]};
                krem_reg[k+1] <= kstep[k][32:1];
                km_reg[k+1]   <= km_reg[k];
                ke_reg[k+1]   <= ke_reg[k];
                ka_reg[k+1]   <= ka_reg[k];
                kgp_reg[k+1]  <= kgp_reg[k];
                kagp_reg[k+1] <= kagp_reg[k];
            end
        end
    end

    // internal energy
    logic signed [63:0] xdiff;
    assign xdiff = 64'(ke_reg[KS]) - $signed({1'b0, kacc_reg[KS]});

    logic signed [31:0] x_reg;
    logic [16:0]        a3_reg, a4_reg, a5_reg, a6_reg, a7_reg;
    logic [30:0]        m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    logic [38:0]        gp3_reg, gp4_reg, gp5_reg, gp6_reg, gp7_reg;
    logic [39:0]        agp3_reg, agp4_reg, agp5_reg;
    logic signed [56:0] y_reg, gx_reg;
    logic signed [40:0] ytr_reg, gxtr_reg;
    logic [55:0]        ymag5_reg, ymag6_reg, ymag7_reg;
    logic               yneg5_reg, yneg6_reg, yneg7_reg;
    logic [40:0]        term6_reg, term7_reg;
    logic signed [31:0] inner_reg;
    logic signed [56:0] prod_reg;

    logic signed [56:0] ysh, gxsh;
    logic [56:0]        yabs;
    logic signed [41:0] tdiff, idiff;

    assign ysh   = (y_reg + (y_reg[56] ? 57'sd65535 : 57'sd0)) >>> 16;
    assign gxsh  = (gx_reg + (gx_reg[56] ? 57'sd65535 : 57'sd0)) >>> 16;
    assign yabs  = y_reg[56] ? 57'(-y_reg) : 57'(y_reg);
    assign tdiff = 42'(ytr_reg) - 42'($signed({1'b0, agp5_reg}));
    assign idiff = 42'(gxtr_reg) - 42'($signed({1'b0, agp5_reg}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= (xdiff < LO64) ? 32'sh8000_0000 : xdiff[31:0];
            a3_reg    <= ka_reg[KS];
            m3_reg    <= km_reg[KS];
            gp3_reg   <= kgp_reg[KS];
            agp3_reg  <= kagp_reg[KS];

            y_reg     <= 57'(g1) * 57'(x_reg);
            gx_reg    <= 57'(gs) * 57'(x_reg);
            a4_reg    <= a3_reg;
            m4_reg    <= m3_reg;
            gp4_reg   <= gp3_reg;
            agp4_reg  <= agp3_reg;

            ytr_reg   <= ysh[40:0];
            gxtr_reg  <= gxsh[40:0];
            ymag5_reg <= yabs[55:0];
            yneg5_reg <= y_reg[56];
            a5_reg    <= a4_reg;
            m5_reg    <= m4_reg;
            gp5_reg   <= gp4_reg;
            agp5_reg  <= agp4_reg;

            term6_reg <= (tdiff <= 42'sd0) ? 41'd1 : tdiff[40:0];
            if (idiff < LO42)
                inner_reg <= 32'sh8000_0000;
            else if (idiff > HI42)
                inner_reg <= 32'sh7fff_ffff;
            else
                inner_reg <= idiff[31:0];
            ymag6_reg <= ymag5_reg;
            yneg6_reg <= yneg5_reg;
            a6_reg    <= a5_reg;
            m6_reg    <= m5_reg;
            gp6_reg   <= gp5_reg;

            prod_reg  <= 57'(g1) * 57'(inner_reg);
            term7_reg <= term6_reg;
            ymag7_reg <= ymag6_reg;
            yneg7_reg <= yneg6_reg;
            a7_reg    <= a6_reg;
            m7_reg    <= m6_reg;
            gp7_reg   <= gp6_reg;
        end
    end

    // pressure quotient over alpha and sound speed quotient over mass
    logic [55:0] pacc_reg [QS+1];
    logic [31:0] prem_reg [QS+1];
    logic [55:0] cacc_reg [QS+1];
    logic [31:0] crem_reg [QS+1];
    logic [16:0] qa_d_reg [QS+1];
    logic [30:0] qm_reg   [QS+1];
    logic        pneg_reg [QS+1];
    logic        cneg_reg [QS+1];
    logic [38:0] qgp_reg  [QS+1];
    logic [40:0] qterm_reg[QS+1];
    logic [32:0] pstep    [QS];
    logic [32:0] cstep    [QS];
    logic [56:0] pabs;

    assign pabs = prod_reg[56] ? 57'(-prod_reg) : 57'(prod_reg);

    always_comb
    begin
        for (int k = 0; k < QS; k++)
        begin
            pstep[k] = sgeos_pkg::div_step(prem_reg[k], pacc_reg[k][55],
                                           32'(qa_d_reg[k]));
            cstep[k] = sgeos_pkg::div_step(crem_reg[k], cacc_reg[k][55],
                                           32'(qm_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pacc_reg[0]  <= ymag7_reg;
            prem_reg[0]  <= '0;
            cacc_reg[0]  <= pabs[55:0];
            crem_reg[0]  <= '0;
            qa_d_reg[0]  <= a7_reg;
            qm_reg[0]    <= m7_reg;
            pneg_reg[0]  <= yneg7_reg;
            cneg_reg[0]  <= prod_reg[56];
            qgp_reg[0]   <= gp7_reg;
            qterm_reg[0] <= term7_reg;
            for (int k = 0; k < QS; k++)
            begin
                pacc_reg[k+1]  <= {pacc_reg[k][54:0], pstep[k][0]};
                prem_reg[k+1]  <= pstep[k][32:1];
                cacc_reg[k+1]  <= {cacc_reg[k][54:0], cstep[k][0]};
                crem_reg[k+1]  <= cstep[k][32:1];
                qa_d_reg[k+1]  <= qa_d_reg[k];
                qm_reg[k+1]    <= qm_reg[k];
                pneg_reg[k+1]  <= pneg_reg[k];
                cneg_reg[k+1]  <= cneg_reg[k];
                qgp_reg[k+1]   <= qgp_reg[k];
                qterm_reg[k+1] <= qterm_reg[k];
            end
        end
    end

    // signed quotients
    logic signed [56:0] qp_reg, qc_reg;
    logic [38:0]        gp9_reg;
    logic [40:0]        term9_reg;
    logic signed [56:0] pq_pos, cq_pos;

    assign pq_pos = $signed({1'b0, pacc_reg[QS]});
    assign cq_pos = $signed({1'b0, cacc_reg[QS]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qp_reg    <= pneg_reg[QS] ? -pq_pos : pq_pos;
            qc_reg    <= cneg_reg[QS] ? -cq_pos : cq_pos;
            gp9_reg   <= qgp_reg[QS];
            term9_reg <= qterm_reg[QS];
        end
    end

    // pressure clamp, c squared clamp, then square root
    logic signed [57:0] pdiff;
    logic signed [31:0] pclamp;
    logic [45:0]        c2low;
    logic               c2sat;

    assign pdiff = 58'(qp_reg) - 58'($signed({1'b0, gp9_reg}));
    assign c2low = (qc_reg <= 57'sd0) ? 46'd1 : qc_reg[45:0];
    assign c2sat = !qc_reg[56] && (qc_reg[55:46] != 10'd0);

    always_comb
    begin
        if (pdiff < LO58)
            pclamp = 32'sh8000_0000;
        else if (pdiff > HI58)
            pclamp = 32'sh7fff_ffff;
        else
            pclamp = pdiff[31:0];
    end

    logic [61:0]        sv_reg   [SS+1];
    logic [32:0]        srem_reg [SS+1];
    logic [30:0]        sroot_reg[SS+1];
    logic signed [31:0] sp_reg   [SS+1];
    logic [40:0]        st_reg   [SS+1];
    logic               ssat_reg [SS+1];
    logic [34:0]        srem2    [SS];
    logic [34:0]        strial   [SS];
    logic [34:0]        sdiff    [SS];

    always_comb
    begin
        for (int k = 0; k < SS; k++)
        begin
            srem2[k]  = {srem_reg[k][32:0], sv_reg[k][61:60]};
            strial[k] = {2'b00, sroot_reg[k], 2'b01};
            sdiff[k]  = srem2[k] - strial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg[0]    <= {c2low, 16'd0};
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            sp_reg[0]    <= pclamp;
            st_reg[0]    <= term9_reg;
            ssat_reg[0]  <= c2sat;
            for (int k = 0; k < SS; k++)
            begin
                sv_reg[k+1] <= {sv_reg[k][59:0], 2'b00};
                if (srem2[k] >= strial[k])
                begin
                    srem_reg[k+1]  <= sdiff[k][32:0];
                    sroot_reg[k+1] <= {sroot_reg[k][29:0], 1'b1};
                end
                else
                begin
                    srem_reg[k+1]  <= srem2[k][32:0];
                    sroot_reg[k+1] <= {sroot_reg[k][29:0], 1'b0};
                end
                sp_reg[k+1]   <= sp_reg[k];
                st_reg[k+1]   <= st_reg[k];
                ssat_reg[k+1] <= ssat_reg[k];
            end
        end
    end

    assign pressure    = sp_reg[SS];
    assign term        = st_reg[SS];
    assign sound_speed = ssat_reg[SS] ? sgeos_pkg::UMAX : sroot_reg[SS];

endmodule
